[rtl/core/jep_pkg.sv]
package jep_pkg;

	localparam int POOL_DEPTH       = 8;
	localparam int SAMPLES_PER_WORD = 32;

	localparam int FILL_W  = (SAMPLES_PER_WORD > 1) ? $clog2(SAMPLES_PER_WORD) : 1;
	localparam int HEAD_W  = $clog2(POOL_DEPTH);
	localparam int USED_W  = $clog2(POOL_DEPTH + 1);
	localparam int WORD_W  = 32;
	localparam int BYTE_W  = 8;
	localparam int OP_W    = 2;
	localparam int COUNT_W = 4;
	localparam int BIDX_W  = 2;

	localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
	localparam logic [OP_W-1:0] OP_WORD   = 2'd1;
	localparam logic [OP_W-1:0] OP_BYTE   = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [BYTE_W-1:0] sample;
	} req_beat_t;

	typedef struct packed {
		logic [WORD_W-1:0]  data;
		logic               ok;
		logic [COUNT_W-1:0] pool_count;
	} rsp_beat_t;

	typedef enum logic [2:0] {
		RES_NONE,
		RES_SAMPLE,
		RES_WORD,
		RES_BYTE_NEW,
		RES_BYTE_OLD
	} res_sel_t;

	typedef struct packed {
		logic              samp_wr;
		logic              pool_rd;
		logic              pool_rd_slot;
		logic              buf_rd;
		logic [FILL_W-1:0] buf_addr;
		logic              h_load;
		logic              h_round;
		logic              h_fin1;
		logic              push;
		logic              pop;
		logic              share_load;
		logic              share_next;
		logic              out_load;
		res_sel_t          out_sel;
	} jep_cmd_t;

	typedef struct packed {
		logic fill_last;
		logic used_zero;
		logic bidx_zero;
	} jep_status_t;

	function automatic logic [WORD_W-1:0] mix_round(input logic [WORD_W-1:0] h,
			input logic [BYTE_W-1:0] b);
		logic [WORD_W-1:0] t;
		t = h + {{(WORD_W-BYTE_W){1'b0}}, b};
		t = t + (t << 10);
		t = t ^ (t >> 6);
		return t;
	endfunction

	function automatic logic [WORD_W-1:0] mix_fin1(input logic [WORD_W-1:0] h);
		logic [WORD_W-1:0] t;
		t = h + (h << 3);
		t = t ^ (t >> 11);
		return t;
	endfunction

	function automatic logic [WORD_W-1:0] mix_fin2(input logic [WORD_W-1:0] h);
		return h + (h << 15);
	endfunction

endpackage

[rtl/core/jitter_entropy_pool.sv]
// A sample beat, a byte read from the held word and an empty-pool read load the result
// register directly; a word or byte read that pops the pool first reads the head, then pops.
// A sample that completes the buffer is mixed into a pool word before its result is given:
// one round per buffered byte through a single shared mixing unit, plus load and finalize.
// Only one item is in flight; the next is taken once the result register is free.
// Reset (async, active low) empties the pool, the sample buffer fill and the byte split.
module jitter_entropy_pool
	import jep_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_beat_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp
);

	jep_cmd_t    cmd;
	jep_status_t status;

	jep_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req.op),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.cmd       (cmd)
	);

	jep_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.status (status),
		.rsp    (rsp)
	);

endmodule

[rtl/core/jep_ctrl.sv]
module jep_ctrl
	import jep_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic [OP_W-1:0] req_op,
	output logic        req_stall,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	input  jep_status_t status,
	output jep_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP_WORD,
		ST_POP_BYTE,
		ST_MIX_RD,
		ST_MIX_RND,
		ST_MIX_FIN1,
		ST_MIX_FIN2
	} state_t;

	localparam logic [FILL_W-1:0] CNT_LAST = FILL_W'(SAMPLES_PER_WORD - 1);

	state_t            state_q;
	state_t            state_d;
	logic [FILL_W-1:0] cnt_q;
	logic              out_valid_q;
	logic              accept;

	assign req_stall = (state_q != ST_IDLE) || (out_valid_q && rsp_stall);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		cmd.out_sel = RES_NONE;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req_op)
						OP_SAMPLE: begin
							cmd.samp_wr = 1'b1;
							if (status.fill_last) begin
								cmd.pool_rd      = 1'b1;
								cmd.pool_rd_slot = 1'b1;
								state_d          = ST_MIX_RD;
							end else begin
								cmd.out_load = 1'b1;
								cmd.out_sel  = RES_SAMPLE;
							end
						end
						OP_WORD: begin
							if (status.used_zero) begin
								cmd.out_load = 1'b1;
							end else begin
								cmd.pool_rd = 1'b1;
								state_d     = ST_POP_WORD;
							end
						end
						OP_BYTE: begin
							if (!status.bidx_zero) begin
								cmd.share_next = 1'b1;
								cmd.out_load   = 1'b1;
								cmd.out_sel    = RES_BYTE_OLD;
							end else if (status.used_zero) begin
								cmd.out_load = 1'b1;
							end else begin
								cmd.pool_rd = 1'b1;
								state_d     = ST_POP_BYTE;
							end
						end
						default: begin
							cmd.out_load = 1'b1;
						end
					endcase
				end
			end
			ST_POP_WORD: begin
				cmd.pop      = 1'b1;
				cmd.out_load = 1'b1;
				cmd.out_sel  = RES_WORD;
				state_d      = ST_IDLE;
			end
			ST_POP_BYTE: begin
				cmd.pop        = 1'b1;
				cmd.share_load = 1'b1;
				cmd.out_load   = 1'b1;
				cmd.out_sel    = RES_BYTE_NEW;
				state_d        = ST_IDLE;
			end
			ST_MIX_RD: begin
				cmd.buf_rd   = 1'b1;
				cmd.buf_addr = '0;
				cmd.h_load   = 1'b1;
				state_d      = ST_MIX_RND;
			end
			ST_MIX_RND: begin
				// prefetch the next byte while this one is folded in
				cmd.buf_rd   = 1'b1;
				cmd.buf_addr = cnt_q + FILL_W'(1);
				cmd.h_round  = 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = ST_MIX_FIN1;
				end
			end
			ST_MIX_FIN1: begin
				cmd.h_fin1 = 1'b1;
				state_d    = ST_MIX_FIN2;
			end
			ST_MIX_FIN2: begin
				cmd.push     = 1'b1;
				cmd.out_load = 1'b1;
				cmd.out_sel  = RES_SAMPLE;
				state_d      = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MIX_RD) begin
				cnt_q <= '0;
			end else if (state_q == ST_MIX_RND) begin
				cnt_q <= cnt_q + FILL_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_fin_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MIX_FIN2) |=> out_valid_q)
		else $error("mix finished without a result beat");

	a_round_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MIX_RND && cnt_q == CNT_LAST) |=> (state_q == ST_MIX_FIN1))
		else $error("round loop did not end after the last byte");

	a_no_load_over_beat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !rsp_stall))
		else $error("result register overwritten while stalled");
`endif

endmodule

[rtl/core/jep_dpath.sv]
module jep_dpath
	import jep_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  req_beat_t   req,
	input  jep_cmd_t    cmd,
	output jep_status_t status,
	output rsp_beat_t   rsp
);

	localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(POOL_DEPTH - 1);
	localparam logic [USED_W-1:0] USED_FULL = USED_W'(POOL_DEPTH);
	localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(SAMPLES_PER_WORD - 1);

	logic [BYTE_W-1:0]  buf_mem [SAMPLES_PER_WORD];
	logic [BYTE_W-1:0]  buf_rd_q;
	logic [FILL_W-1:0]  fill_q;

	logic [WORD_W-1:0]  pool_mem [POOL_DEPTH];
	logic [POOL_DEPTH-1:0] pool_vld_q;
	logic [WORD_W-1:0]  pool_rd_q;
	logic [HEAD_W-1:0]  head_q;
	logic [USED_W-1:0]  used_q;
	logic [USED_W-1:0]  used_d;
	logic [HEAD_W-1:0]  head_inc;
	logic [HEAD_W:0]    slot_sum;
	logic [HEAD_W-1:0]  slot;
	logic [HEAD_W-1:0]  rd_addr;

	logic [WORD_W-1:0]  h_q;
	logic [WORD_W-1:0]  share_q;
	logic [BIDX_W-1:0]  bidx_q;
	rsp_beat_t          rsp_q;
	logic [WORD_W-1:0]  data_d;

	assign head_inc = (head_q == HEAD_LAST) ? '0 : head_q + HEAD_W'(1);
	assign slot_sum = {1'b0, head_q} + (HEAD_W+1)'(used_q);
	assign slot     = (slot_sum >= (HEAD_W+1)'(POOL_DEPTH)) ?
		HEAD_W'(slot_sum - (HEAD_W+1)'(POOL_DEPTH)) : HEAD_W'(slot_sum);
	assign rd_addr  = cmd.pool_rd_slot ? slot : head_q;

	always_comb begin
		used_d = used_q;
		if (cmd.push && used_q != USED_FULL) begin
			used_d = used_q + USED_W'(1);
		end else if (cmd.pop) begin
			used_d = used_q - USED_W'(1);
		end
	end

	assign status.fill_last = (fill_q == FILL_LAST);
	assign status.used_zero = (used_q == '0);
	assign status.bidx_zero = (bidx_q == '0);

	always_comb begin
		case (cmd.out_sel)
			RES_SAMPLE:   data_d = '0;
			RES_WORD:     data_d = pool_rd_q;
			RES_BYTE_NEW: data_d = {{(WORD_W-BYTE_W){1'b0}}, pool_rd_q[BYTE_W-1:0]};
			RES_BYTE_OLD: data_d = {{(WORD_W-BYTE_W){1'b0}}, share_q[bidx_q*BYTE_W +: BYTE_W]};
			default:      data_d = '0;
		endcase
	end

	// memories and payload: no reset
	always_ff @(posedge clk) begin
		if (cmd.samp_wr) begin
			buf_mem[fill_q] <= req.sample;
		end
		if (cmd.buf_rd) begin
			buf_rd_q <= buf_mem[cmd.buf_addr];
		end
		if (cmd.push) begin
			pool_mem[slot] <= mix_fin2(h_q);
		end
		if (cmd.pool_rd) begin
			pool_rd_q <= pool_vld_q[rd_addr] ? pool_mem[rd_addr] : '0;
		end
		if (cmd.h_load) begin
			h_q <= pool_rd_q;
		end else if (cmd.h_round) begin
			h_q <= mix_round(h_q, buf_rd_q);
		end else if (cmd.h_fin1) begin
			h_q <= mix_fin1(h_q);
		end
		if (cmd.out_load) begin
			rsp_q.data       <= data_d;
			rsp_q.ok         <= (cmd.out_sel != RES_NONE);
			rsp_q.pool_count <= COUNT_W'(used_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			pool_vld_q <= '0;
			head_q     <= '0;
			used_q     <= '0;
			share_q    <= '0;
			bidx_q     <= '0;
		end else begin
			if (cmd.samp_wr) begin
				fill_q <= (fill_q == FILL_LAST) ? '0 : fill_q + FILL_W'(1);
			end
			if (cmd.push) begin
				pool_vld_q[slot] <= 1'b1;
			end
			// full pool: newest word overwrote the oldest, so advance head
			if (cmd.pop || (cmd.push && used_q == USED_FULL)) begin
				head_q <= head_inc;
			end
			used_q <= used_d;
			if (cmd.share_load) begin
				share_q <= pool_rd_q;
				bidx_q  <= bidx_q + BIDX_W'(1);
			end else if (cmd.share_next) begin
				bidx_q  <= bidx_q + BIDX_W'(1);
			end
		end
	end

	assign rsp = rsp_q;

`ifndef SYNTHESIS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_FULL)
		else $error("pool count above depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (used_q != '0))
		else $error("pop from empty pool");

	a_fill_clear_on_push: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (fill_q == '0))
		else $error("sample buffer not restarted when word pushed");
`endif

endmodule
